// ===== hdl/shx20_pkg.sv =====
// shared types and constants for the 20-node serendipity hexahedron mapper
// no dependencies; used by shx20_node_store and serendipity_hex20_map
`default_nettype none

package shx20_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NODE_COUNT = 20;
    localparam int NODE_STEPS = 20;   // 8 shape steps then 12 accumulate steps
    localparam int SHAPE_STEPS = 8;
    localparam int COORD_W    = 32;
    localparam int POINT_W    = 18;
    localparam int ACC_W      = 48;
    localparam int N_OUT      = 12;
    localparam int ROW_W      = 3 * COORD_W;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    // node signs, two bits per axis {zeta, eta, qsi}: 01 = +1, 11 = -1, 00 = 0
    typedef logic [5:0] sign_row_t;

    localparam sign_row_t NODE_SIGN [NODE_COUNT] = '{
        6'b111111, 6'b111101, 6'b110101, 6'b110111,
        6'b011111, 6'b011101, 6'b010101, 6'b010111,
        6'b111100, 6'b110001, 6'b110100, 6'b110011,
        6'b001111, 6'b001101, 6'b000101, 6'b000111,
        6'b011100, 6'b010001, 6'b010100, 6'b010011
    };

endpackage

`default_nettype wire

// ===== hdl/serendipity_hex20_map.sv =====
// 20-node serendipity hexahedron: maps a reference point to position and jacobian
// depends on shx20_pkg and shx20_node_store
//
// Input channel s_*: tuser carries req_type. A load transaction (req_type 0)
// writes node_index's x, y, z; an index above 19 is dropped.
// An evaluate transaction (req_type 1) carries qsi, eta, zeta and yields one
// result transaction on m_*: mapped position and the 3x3 jacobian, Q15.16
// saturated. Every node must be loaded before the first evaluate.
// One signed 32x32 multiplier does all the work: per node, the shape steps form
// the shape value and its three derivatives, then the accumulate steps multiply
// them against the node's coordinates into the sums, which are presented as the
// result after the last node. s_tready is low from the accepted
// evaluate until the result transaction has been taken; while the receiver
// stalls, the result holds on m_tdata. Reset clears the sequencer and the
// output valid; the node store keeps whatever it held.
`default_nettype none

module serendipity_hex20_map (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // node_index, coord_x, coord_y, coord_z, point_qsi, point_eta, point_zeta, zero pad
    input  wire logic [159:0] s_tdata,
    // req_type
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x, pos_y, pos_z, jac_x_qsi, jac_x_eta, jac_x_zeta, jac_y_qsi,
    // jac_y_eta, jac_y_zeta, jac_z_qsi, jac_z_eta, jac_z_zeta
    output logic      [383:0] m_tdata
);

    shx20_pkg::state_t state_reg, state_next;

    logic [4:0] node_reg;
    logic [4:0] step_reg;
    logic signed [shx20_pkg::POINT_W-1:0] p_reg [3];
    logic signed [31:0] t_reg [4];
    logic signed [31:0] sh_reg [4];
    logic signed [shx20_pkg::ACC_W-1:0] acc_reg [shx20_pkg::N_OUT];

    logic [shx20_pkg::ROW_W-1:0] row;
    logic s_acc, load_we;
    logic [4:0] load_idx;

    assign s_tready = (state_reg == shx20_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == shx20_pkg::ST_OUT);
    assign s_acc    = s_tvalid && s_tready;
    assign load_idx = s_tdata[4:0];
    assign load_we  = s_acc && (s_tuser[0] == shx20_pkg::REQ_LOAD)
                      && (load_idx < 5'(shx20_pkg::NODE_COUNT));

    shx20_node_store u_store (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (load_idx),
        .wdata (s_tdata[100:5]),
        .raddr (node_reg),
        .rdata (row)
    );

    // per-node geometry
    shx20_pkg::sign_row_t sgn;
    logic signed [1:0]  s [3];
    logic signed [31:0] sp [3];
    logic signed [31:0] lv [3];
    logic signed [31:0] g [3];
    logic signed [31:0] ssum, sm2;
    logic [1:0] zax, jax, max_i;
    logic is_corner;

    always_comb begin
        sgn = shx20_pkg::NODE_SIGN[node_reg];
        zax = 2'd0;
        for (int k = 0; k < 3; k++) begin
            s[k]  = sgn[2*k +: 2];
            sp[k] = (s[k] == 2'sd0) ? 32'sd0 :
                    (s[k][1] ? -32'(p_reg[k]) : 32'(p_reg[k]));
            lv[k] = shx20_pkg::ONE + sp[k];
        end
        for (int k = 2; k >= 0; k--) begin
            if (s[k] == 2'sd0) zax = 2'(k);
        end
        is_corner = (s[0] != 2'sd0) && (s[1] != 2'sd0) && (s[2] != 2'sd0);
        jax   = (zax == 2'd0) ? 2'd1 : 2'd0;
        max_i = (zax == 2'd2) ? 2'd1 : 2'd2;
        ssum  = sp[0] + sp[1] + sp[2];
        sm2   = ssum - (shx20_pkg::ONE <<< 1);
        for (int k = 0; k < 3; k++) begin
            g[k] = ssum + sp[k] - shx20_pkg::ONE;
        end
    end

    // shared multiplier
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod, fm;
    logic signed [31:0] fm32;
    logic [3:0] ai;
    logic [1:0] ax, dd;
    logic [3:0] acc_idx;

    always_comb begin
        ai = 4'(step_reg - 5'(shx20_pkg::SHAPE_STEPS));
        ax = ai[3:2];
        dd = ai[1:0];
        acc_idx = (dd == 2'd0) ? 4'(ax) : 4'(4'd3 + 4'(ax) * 4'd3 + 4'(dd) - 4'd1);
        ma = 32'sd0;
        mb = 32'sd0;
        if (step_reg >= 5'(shx20_pkg::SHAPE_STEPS)) begin
            ma = sh_reg[dd];
            mb = $signed(row[32*ax +: 32]);
        end else if (is_corner) begin
            unique case (step_reg[2:0])
                3'd0: begin ma = lv[0];    mb = lv[1]; end
                3'd1: begin ma = lv[1];    mb = lv[2]; end
                3'd2: begin ma = lv[0];    mb = lv[2]; end
                3'd3: begin ma = t_reg[0]; mb = lv[2]; end
                3'd4: begin ma = t_reg[3]; mb = sm2;   end
                3'd5: begin ma = t_reg[1]; mb = g[0];  end
                3'd6: begin ma = t_reg[2]; mb = g[1];  end
                default: begin ma = t_reg[0]; mb = g[2]; end
            endcase
        end else begin
            unique case (step_reg[2:0])
                3'd0: begin ma = 32'(p_reg[zax]); mb = 32'(p_reg[zax]); end
                3'd1: begin ma = t_reg[0]; mb = lv[jax];   end
                3'd2: begin ma = t_reg[0]; mb = lv[max_i]; end
                3'd3: begin ma = t_reg[1]; mb = lv[max_i]; end
                3'd4: begin ma = 32'(p_reg[zax]); mb = lv[jax]; end
                3'd5: begin ma = t_reg[3]; mb = lv[max_i]; end
                default: begin ma = 32'sd0; mb = 32'sd0; end
            endcase
        end
        prod = ma * mb;
        fm   = (prod + (64'sd1 <<< (shx20_pkg::FRAC_BITS - 1))) >>> shx20_pkg::FRAC_BITS;
        fm32 = fm[31:0];
    end

    function automatic logic signed [31:0] rsh(input logic signed [31:0] v,
                                               input int sh);
        rsh = (v + (32'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] sgnv(input logic signed [1:0] sv,
                                                input logic signed [31:0] v);
        sgnv = sv[1] ? -v : v;
    endfunction

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            shx20_pkg::ST_IDLE:
                if (s_acc && s_tuser[0] == shx20_pkg::REQ_EVAL) state_next = shx20_pkg::ST_CALC;
            shx20_pkg::ST_CALC:
                if (node_reg == 5'(shx20_pkg::NODE_COUNT - 1)
                    && step_reg == 5'(shx20_pkg::NODE_STEPS - 1))
                    state_next = shx20_pkg::ST_OUT;
            shx20_pkg::ST_OUT:
                if (m_tready) state_next = shx20_pkg::ST_IDLE;
            default: state_next = shx20_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shx20_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == shx20_pkg::ST_IDLE) begin
            node_reg <= 5'd0;
            step_reg <= 5'd0;
            if (s_acc) begin
                p_reg[0] <= $signed(s_tdata[118:101]);
                p_reg[1] <= $signed(s_tdata[136:119]);
                p_reg[2] <= $signed(s_tdata[154:137]);
                for (int i = 0; i < shx20_pkg::N_OUT; i++) acc_reg[i] <= '0;
            end
        end else if (state_reg == shx20_pkg::ST_CALC) begin
            if (step_reg == 5'(shx20_pkg::NODE_STEPS - 1)) begin
                step_reg <= 5'd0;
                node_reg <= node_reg + 5'd1;
            end else begin
                step_reg <= step_reg + 5'd1;
            end
            if (step_reg >= 5'(shx20_pkg::SHAPE_STEPS)) begin
                acc_reg[acc_idx] <= acc_reg[acc_idx] + fm[shx20_pkg::ACC_W-1:0];
            end else if (is_corner) begin
                unique case (step_reg[2:0])
                    3'd0: t_reg[0] <= fm32;
                    3'd1: t_reg[1] <= fm32;
                    3'd2: t_reg[2] <= fm32;
                    3'd3: t_reg[3] <= fm32;
                    3'd4: sh_reg[0] <= rsh(fm32, 3);
                    3'd5: sh_reg[1] <= sgnv(s[0], rsh(fm32, 3));
                    3'd6: sh_reg[2] <= sgnv(s[1], rsh(fm32, 3));
                    default: sh_reg[3] <= sgnv(s[2], rsh(fm32, 3));
                endcase
            end else begin
                unique case (step_reg[2:0])
                    3'd0: t_reg[0] <= shx20_pkg::ONE - fm32;   // q = 1 - p^2
                    3'd1: t_reg[1] <= fm32;
                    3'd2: t_reg[2] <= fm32;
                    3'd3: sh_reg[0] <= rsh(fm32, 2);
                    3'd4: t_reg[3] <= fm32;
                    3'd5: sh_reg[2'(zax + 2'd1)] <= -rsh(fm32, 1);
                    3'd6: begin
                        sh_reg[2'(jax + 2'd1)]   <= sgnv(s[jax], rsh(t_reg[2], 2));
                        sh_reg[2'(max_i + 2'd1)] <= sgnv(s[max_i], rsh(t_reg[1], 2));
                    end
                    default: ;
                endcase
            end
        end
    end

    // saturate the sums onto the result bus
    always_comb begin
        for (int i = 0; i < shx20_pkg::N_OUT; i++) begin
            if (acc_reg[i] > 48'sh0000_7FFF_FFFF)
                m_tdata[32*i +: 32] = 32'h7FFF_FFFF;
            else if (acc_reg[i] < -48'sh0000_8000_0000)
                m_tdata[32*i +: 32] = 32'h8000_0000;
            else
                m_tdata[32*i +: 32] = acc_reg[i][31:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/shx20_node_store.sv =====
// node coordinate store: 20 rows of x, y, z (Q15.16), registered read
// depends on shx20_pkg
`default_nettype none

module shx20_node_store (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [4:0]                    waddr,
    input  wire logic [shx20_pkg::ROW_W-1:0]   wdata,
    input  wire logic [4:0]                    raddr,
    output logic      [shx20_pkg::ROW_W-1:0]   rdata
);

    logic [shx20_pkg::ROW_W-1:0] mem [shx20_pkg::NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
